// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CWM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CWM_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWM_ASSERT(name, clk, rst_n, prop, msg)
`define CWM_ASSERT_NR(name, clk, prop, msg)
`endif
`endif

// ===== rtl/core/cwm_pkg.sv =====
// types and constants of the channel wall force block
package cwm_pkg;
  localparam int GW         = 52;
  localparam int CFG_IDX_W  = 8;
  localparam int Q_LN2      = 45426;
  localparam int EXP_HI     = 15 * Q_LN2;
  localparam int EXP_OFF    = 16 * Q_LN2;
  localparam int RECIP_LN2  = 1512779;
  localparam int TAYLOR_N   = 12;
  localparam int SHARE_LAT  = 65;
  localparam longint unsigned X_CAP   = 64'd1 << 40;
  localparam longint unsigned MAG_CAP = 64'd1 << 47;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_H   = 8'd0,
    REG_CH_WIDTH  = 8'd1,
    REG_CH_LENGTH = 8'd2,
    REG_MID_RATIO = 8'd3,
    REG_DRAG      = 8'd4
  } cwm_reg_e;
endpackage

// ===== rtl/core/cwm_if.sv =====
// request, result and configuration channel interfaces of the channel wall force block
interface cwm_item_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_vertical;
  logic signed [31:0] pos_lateral;
  logic [30:0]        cell_radius;
  logic [30:0]        well_depth;
  logic [30:0]        well_width;
  logic signed [31:0] vel_vertical;
  logic signed [31:0] vel_lateral;
  logic               last_cell;
  modport source (output valid, pos_vertical, pos_lateral, cell_radius, well_depth,
                  well_width, vel_vertical, vel_lateral, last_cell, input ready);
  modport sink (input valid, pos_vertical, pos_lateral, cell_radius, well_depth,
                well_width, vel_vertical, vel_lateral, last_cell, output ready);
endinterface

interface cwm_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel_vertical;
  logic signed [31:0] new_vel_lateral;
  logic signed [31:0] wall_vel_vertical;
  logic signed [31:0] wall_vel_lateral;
  logic               last_out;
  modport source (output valid, new_vel_vertical, new_vel_lateral, wall_vel_vertical,
                  wall_vel_lateral, last_out, input ready);
  modport sink (input valid, new_vel_vertical, new_vel_lateral, wall_vel_vertical,
                wall_vel_lateral, last_out, output ready);
endinterface

interface cwm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [cwm_pkg::CFG_IDX_W-1:0]    index;
  logic [31:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cwm_share.sv =====
// pipelined morse wall share: distance to velocity share over drag
module cwm_share (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [cwm_pkg::GW-1:0] d2_i,
  input  logic [30:0]                   de_i,
  input  logic [30:0]                   a_i,
  input  logic [30:0]                   drag_i,
  output logic signed [31:0]            share_o
);
  import cwm_pkg::*;

  typedef struct packed {
    logic        hi;
    logic        lo;
    logic [4:0]  q;
    logic [31:0] fr;
    logic [31:0] term;
    logic [33:0] sum;
  } exp_t;

  localparam int NS = 2 * (TAYLOR_N - 1);
  localparam int DQ = 33;
  localparam int PD = NS + 4;

  // a*d and 2*De*a products
  logic [GW-1:0] md;
  logic [56:0]   ppl_q, pph_q;
  logic [62:0]   pa_q;
  logic          neg_a_q;

  assign md = d2_i[GW-1] ? $unsigned(-d2_i) : $unsigned(d2_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ppl_q   <= 57'(md[25:0]) * 57'(a_i);
      pph_q   <= 57'(md[51:26]) * 57'(a_i);
      pa_q    <= 63'({de_i, 1'b0}) * 63'(a_i);
      neg_a_q <= d2_i[GW-1];
    end
  end

  // scaled exponent arguments
  logic [82:0]        prod_b;
  logic [65:0]        sh_b;
  logic [40:0]        mx_b;
  logic signed [42:0] zb [2];
  logic signed [42:0] z_q [2];
  logic [46:0]        p1_b_q;

  assign prod_b = 83'(ppl_q) + (83'(pph_q) << 26);
  assign sh_b   = prod_b[82:17];
  assign mx_b   = (sh_b > 66'(X_CAP)) ? 41'(X_CAP) : sh_b[40:0];
  assign zb[0]  = neg_a_q ? $signed(43'(mx_b)) : -$signed(43'(mx_b));
  assign zb[1]  = neg_a_q ? $signed({1'b0, mx_b, 1'b0}) : -$signed({1'b0, mx_b, 1'b0});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q    <= zb;
      p1_b_q <= pa_q[62:16];
    end
  end

  // two exponential units
  logic        c_hi_q [2];
  logic        c_lo_q [2];
  logic [20:0] c_zp_q [2];
  logic        d_hi_q [2];
  logic        d_lo_q [2];
  logic [20:0] d_zp_q [2];
  logic [4:0]  d_k_q  [2];
  exp_t        xs_q   [2][NS+1];
  logic [30:0] e_q    [2];
  logic [46:0] p1_q   [PD];

  for (genvar e = 0; e < 2; e++) begin : g_exp
    logic [41:0] qd;
    logic [20:0] f_e;
    logic [31:0] fr_e;
    logic [5:0]  sh_f;
    logic [33:0] res_f;

    assign qd    = 42'(c_zp_q[e]) * 42'(RECIP_LN2);
    assign f_e   = d_zp_q[e] - 21'(21'(d_k_q[e]) * 21'(Q_LN2));
    assign fr_e  = {f_e[15:0], 16'h0000};
    assign sh_f  = 6'd32 - 6'(xs_q[e][NS].q);
    assign res_f = xs_q[e][NS].sum >> sh_f;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_hi_q[e] <= z_q[e] >= 43'(EXP_HI);
        c_lo_q[e] <= z_q[e] < -43'(EXP_OFF);
        c_zp_q[e] <= 21'(z_q[e] + 43'(EXP_OFF));
        d_hi_q[e] <= c_hi_q[e];
        d_lo_q[e] <= c_lo_q[e];
        d_zp_q[e] <= c_zp_q[e];
        d_k_q[e]  <= qd[40:36];
        xs_q[e][0] <= '{hi: d_hi_q[e], lo: d_lo_q[e], q: d_k_q[e], fr: fr_e,
                        term: fr_e, sum: 34'h1_0000_0000 + 34'(fr_e)};
        if (xs_q[e][NS].hi) begin
          e_q[e] <= 31'h7fff_ffff;
        end else if (xs_q[e][NS].lo) begin
          e_q[e] <= '0;
        end else if (res_f > 34'h0_7fff_ffff) begin
          e_q[e] <= 31'h7fff_ffff;
        end else begin
          e_q[e] <= res_f[30:0];
        end
      end
    end

    for (genvar n = 2; n <= TAYLOR_N; n++) begin : g_term
      localparam longint unsigned MN = ((64'd1 << 36) + 64'(n) - 64'd1) / 64'(n);
      logic [63:0] prp;
      logic [67:0] prq;
      exp_t        mul_d;
      exp_t        div_d;

      assign prp = 64'(xs_q[e][2*n-4].term) * 64'(xs_q[e][2*n-4].fr);
      assign prq = 68'(xs_q[e][2*n-3].term) * 68'(MN);

      always_comb begin
        mul_d      = xs_q[e][2*n-4];
        mul_d.term = prp[63:32];
        div_d      = xs_q[e][2*n-3];
        div_d.term = prq[67:36];
        div_d.sum  = xs_q[e][2*n-3].sum + 34'(prq[67:36]);
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          xs_q[e][2*n-3] <= mul_d;
          xs_q[e][2*n-2] <= div_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q[0] <= p1_b_q;
    end
  end

  for (genvar i = 1; i < PD; i++) begin : g_p1
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p1_q[i] <= p1_q[i-1];
      end
    end
  end

  // force = p1 * (exp(-x) - exp(-2x))
  logic signed [31:0] term_g;
  logic [30:0]        mt_g;
  logic [54:0]        gl_q;
  logic [53:0]        gh_q;
  logic               g_neg_q;

  assign term_g = $signed({1'b0, e_q[0]}) - $signed({1'b0, e_q[1]});
  assign mt_g   = term_g[31] ? 31'(-term_g) : term_g[30:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gl_q    <= 55'(p1_q[PD-1][23:0]) * 55'(mt_g);
      gh_q    <= 54'(p1_q[PD-1][46:24]) * 54'(mt_g);
      g_neg_q <= term_g[31];
    end
  end

  logic [77:0] prod_h;
  logic [61:0] s_h;
  logic [47:0] mf_h;
  logic [63:0] h_div_q;
  logic        h_neg_q;

  assign prod_h = 78'(gl_q) + (78'(gh_q) << 24);
  assign s_h    = prod_h[77:16];
  assign mf_h   = (s_h > 62'(MAG_CAP)) ? 48'(MAG_CAP) : s_h[47:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_div_q <= {mf_h, 16'h0000};
      h_neg_q <= g_neg_q;
    end
  end

  // restoring divide by drag, one quotient bit a stage
  logic [30:0] gg;
  logic [63:0] rem_q  [DQ+1];
  logic [32:0] quo_q  [DQ+1];
  logic        ovf_q  [DQ+1];
  logic        dneg_q [DQ+1];

  assign gg = (drag_i == '0) ? 31'd1 : drag_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= h_div_q;
      quo_q[0]  <= '0;
      ovf_q[0]  <= h_div_q >= (64'(gg) << 33);
      dneg_q[0] <= h_neg_q;
    end
  end

  for (genvar j = 1; j <= DQ; j++) begin : g_div
    logic [63:0] cand;
    assign cand = 64'(gg) << (DQ - j);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ovf_q[j]  <= ovf_q[j-1];
        dneg_q[j] <= dneg_q[j-1];
        if (rem_q[j-1] >= cand) begin
          rem_q[j] <= rem_q[j-1] - cand;
          quo_q[j] <= quo_q[j-1] | (33'd1 << (DQ - j));
        end else begin
          rem_q[j] <= rem_q[j-1];
          quo_q[j] <= quo_q[j-1];
        end
      end
    end
  end

  logic [32:0]        qv;
  logic [32:0]        qn;
  logic signed [31:0] share_q;

  assign qv = quo_q[DQ];
  assign qn = 33'd0 - qv;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (dneg_q[DQ]) begin
        share_q <= (ovf_q[DQ] || qv > 33'h0_8000_0000) ? 32'sh8000_0000 : $signed(qn[31:0]);
      end else begin
        share_q <= (ovf_q[DQ] || qv > 33'h0_7fff_ffff) ? 32'sh7fff_ffff : $signed(qv[31:0]);
      end
    end
  end

  assign share_o = share_q;
endmodule

// ===== rtl/core/channel_wall_morse_force.sv =====
// top level of the channel wall morse force block
//
//  channel   | dir | carries
//  cell_i    | in  | one cell request: position, radius, well, velocity, last flag
//  result_o  | out | new velocity, wall velocity, last flag
//  cfg_i     | in  | register writes: index and data
//
// one cell enters every cycle unless a stalled result holds the pipeline, set by
// the pipelined exponential, product and 33 stage divider path
// reset clears the valid bits and loads the register defaults
// a stalled result holds the whole pipeline; nothing is dropped or repeated
`include "assert_macros.svh"

module channel_wall_morse_force (
  input  logic          clk_i,
  input  logic          rst_ni,
  cwm_item_if.sink      cell_i,
  cwm_result_if.source  result_o,
  cwm_cfg_if.sink       cfg_i
);
  import cwm_pkg::*;

  typedef struct packed {
    logic signed [31:0] vv;
    logic signed [31:0] vl;
    logic               last;
    logic               v_en;
    logic               v_neg;
    logic               l0_en;
    logic               l1_en;
  } side_t;

  localparam int NV = 3 + SHARE_LAT + 1;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // configuration registers
  logic [30:0] cfg_h_q, cfg_w_q, cfg_l_q, cfg_ratio_q, cfg_drag_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_h_q     <= '0;
      cfg_w_q     <= '0;
      cfg_l_q     <= '0;
      cfg_ratio_q <= 31'd65536;
      cfg_drag_q  <= 31'd65536;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_UPPER_H:   cfg_h_q     <= cfg_i.data[30:0];
        REG_CH_WIDTH:  cfg_w_q     <= cfg_i.data[30:0];
        REG_CH_LENGTH: cfg_l_q     <= cfg_i.data[30:0];
        REG_MID_RATIO: cfg_ratio_q <= cfg_i.data[30:0];
        REG_DRAG:      cfg_drag_q  <= cfg_i.data[30:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          en;
  logic [NV-1:0] vld_q;

  assign en           = !(vld_q[NV-1] && !result_o.ready);
  assign cell_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], cell_i.valid};
    end
  end

  // stage 1: capture and chamber height product
  logic signed [31:0] s1_pv_q, s1_pl_q, s1_vv_q, s1_vl_q;
  logic [30:0]        s1_r_q, s1_de_q, s1_a_q;
  logic               s1_last_q;
  logic [45:0]        s1_hr_q;
  logic [61:0]        hr_prod;

  assign hr_prod = 62'(cfg_h_q) * 62'(cfg_ratio_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pv_q   <= cell_i.pos_vertical;
      s1_pl_q   <= cell_i.pos_lateral;
      s1_r_q    <= cell_i.cell_radius;
      s1_de_q   <= cell_i.well_depth;
      s1_a_q    <= cell_i.well_width;
      s1_vv_q   <= cell_i.vel_vertical;
      s1_vl_q   <= cell_i.vel_lateral;
      s1_last_q <= cell_i.last_cell;
      s1_hr_q   <= hr_prod[61:16];
    end
  end

  // stage 2: wall lines at doubled scale
  logic signed [GW-1:0] sp0, sp1, sr2, sh, sw, sl2, shr2;
  logic signed [GW-1:0] s2_p0_q, s2_p1_q, s2_r2_q, s2_w_q;
  logic signed [GW-1:0] s2_la_q, s2_lb_q, s2_lc_q, s2_lf_q, s2_lg_q, s2_lh_q, s2_li_q;
  logic signed [31:0]   s2_vv_q, s2_vl_q;
  logic [30:0]          s2_de_q, s2_a_q;
  logic                 s2_last_q;

  assign sp0  = GW'(s1_pv_q) <<< 1;
  assign sp1  = GW'(s1_pl_q) <<< 1;
  assign sr2  = $signed(GW'({s1_r_q, 1'b0}));
  assign sh   = $signed(GW'(cfg_h_q));
  assign sw   = $signed(GW'(cfg_w_q));
  assign sl2  = $signed(GW'({cfg_l_q, 1'b0}));
  assign shr2 = $signed(GW'({s1_hr_q, 1'b0}));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_p0_q   <= sp0;
      s2_p1_q   <= sp1;
      s2_r2_q   <= sr2;
      s2_w_q    <= sw;
      s2_la_q   <= sh - sr2;
      s2_lb_q   <= sr2 - sh;
      s2_lc_q   <= -sh;
      s2_lf_q   <= -sh - sl2;
      s2_lg_q   <= -sh - sl2 - sr2;
      s2_lh_q   <= -sh - sl2 - shr2 + sr2;
      s2_li_q   <= -sh - sl2 - shr2;
      s2_vv_q   <= s1_vv_q;
      s2_vl_q   <= s1_vl_q;
      s2_de_q   <= s1_de_q;
      s2_a_q    <= s1_a_q;
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: zone select and wall distances
  logic                 outside, z_ceil, z_uf, z_c1, z_mc, z_mf, z_c2, chan;
  logic signed [GW-1:0] left_d, right_d;
  logic signed [GW-1:0] d0;
  side_t                side_n;
  logic signed [GW-1:0] s3_d0_q, s3_d1_q;
  logic [30:0]          s3_de_q, s3_a_q;
  side_t                s3_side_q;

  assign left_d  = s2_p1_q - s2_r2_q + s2_w_q;
  assign right_d = s2_w_q - s2_p1_q - s2_r2_q;

  always_comb begin
    outside = (s2_p1_q < -s2_w_q) || (s2_p1_q > s2_w_q);
    z_ceil  = s2_p0_q > s2_la_q;
    z_uf    = (s2_p0_q < s2_lb_q) && (s2_p0_q > s2_lc_q);
    z_c1    = (s2_p0_q < s2_lc_q) && (s2_p0_q > s2_lf_q);
    z_mc    = (s2_p0_q < s2_lf_q) && (s2_p0_q > s2_lg_q);
    z_mf    = (s2_p0_q < s2_lh_q) && (s2_p0_q > s2_li_q);
    z_c2    = s2_p0_q < s2_li_q;
    chan    = 1'b0;
    side_n  = '{vv: s2_vv_q, vl: s2_vl_q, last: s2_last_q,
                v_en: 1'b0, v_neg: 1'b0, l0_en: 1'b0, l1_en: 1'b0};
    d0      = left_d;
    if (z_ceil) begin
      side_n.v_en = 1'b1;
      d0          = s2_la_q - s2_p0_q;
    end else if (z_uf) begin
      side_n.v_en  = outside;
      side_n.v_neg = 1'b1;
      d0           = s2_p0_q - s2_lb_q;
    end else if (z_c1) begin
      chan = 1'b1;
    end else if (z_mc) begin
      side_n.v_en = outside;
      d0          = s2_lg_q - s2_p0_q;
    end else if (z_mf) begin
      side_n.v_en  = outside;
      side_n.v_neg = 1'b1;
      d0           = s2_p0_q - s2_lh_q;
    end else if (z_c2) begin
      chan = 1'b1;
    end
    side_n.l0_en = chan && (left_d < 0);
    side_n.l1_en = chan && (right_d < 0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_d0_q   <= d0;
      s3_d1_q   <= right_d;
      s3_de_q   <= s2_de_q;
      s3_a_q    <= s2_a_q;
      s3_side_q <= side_n;
    end
  end

  // two share lanes
  logic signed [31:0] share0, share1;

  cwm_share u_share0 (
    .clk_i   (clk_i),
    .en_i    (en),
    .d2_i    (s3_d0_q),
    .de_i    (s3_de_q),
    .a_i     (s3_a_q),
    .drag_i  (cfg_drag_q),
    .share_o (share0)
  );

  cwm_share u_share1 (
    .clk_i   (clk_i),
    .en_i    (en),
    .d2_i    (s3_d1_q),
    .de_i    (s3_de_q),
    .a_i     (s3_a_q),
    .drag_i  (cfg_drag_q),
    .share_o (share1)
  );

  side_t side_q [SHARE_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s3_side_q;
    end
  end

  for (genvar i = 1; i < SHARE_LAT; i++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // output stage
  side_t              so;
  logic signed [34:0] wv_sum, wl_sum;
  logic signed [31:0] wv, wl;
  logic signed [31:0] nv_q, nl_q, wv_q, wl_q;
  logic               last_q;

  assign so     = side_q[SHARE_LAT-1];
  assign wv_sum = so.v_en ? (so.v_neg ? -35'(share0) : 35'(share0)) : '0;
  assign wl_sum = (so.l0_en ? -35'(share0) : 35'sd0) + (so.l1_en ? 35'(share1) : 35'sd0);
  assign wv     = sat32(wv_sum);
  assign wl     = sat32(wl_sum);

  always_ff @(posedge clk_i) begin
    if (en) begin
      wv_q   <= wv;
      wl_q   <= wl;
      nv_q   <= sat32(35'(so.vv) + 35'(wv));
      nl_q   <= sat32(35'(so.vl) + 35'(wl));
      last_q <= so.last;
    end
  end

  assign result_o.valid             = vld_q[NV-1];
  assign result_o.new_vel_vertical  = nv_q;
  assign result_o.new_vel_lateral   = nl_q;
  assign result_o.wall_vel_vertical = wv_q;
  assign result_o.wall_vel_lateral  = wl_q;
  assign result_o.last_out          = last_q;

  `CWM_ASSERT(a_axes_exclusive, clk_i, rst_ni, result_o.valid |-> (result_o.wall_vel_vertical == '0 || result_o.wall_vel_lateral == '0), "wall velocity on both axes")
  `CWM_ASSERT(a_vert_idle, clk_i, rst_ni, (vld_q[NV-2] && en && !so.v_en) |=> (result_o.wall_vel_vertical == '0), "vertical wall velocity without a wall")
  `CWM_ASSERT(a_lat_idle, clk_i, rst_ni, (vld_q[NV-2] && en && !so.l0_en && !so.l1_en) |=> (result_o.wall_vel_lateral == '0), "lateral wall velocity without a wall")
  `CWM_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !result_o.valid, "result valid in reset")
endmodule
